// File: rtl/core/pagerank_push_csr_engine_defines.svh
// Assertion macros shared by the engine RTL.
`ifndef PAGERANK_PUSH_CSR_ENGINE_DEFINES_SVH
`define PAGERANK_PUSH_CSR_ENGINE_DEFINES_SVH

// Same-cycle implication checked on every clock edge out of reset.
`define PR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("engine check failed");

// Next-cycle implication checked on every clock edge out of reset.
`define PR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("engine check failed");

`endif

// File: rtl/core/pr_pkg.sv
// ----------------------------------------------------------------------------
// PageRank engine package
// Shared sizes, command codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pr_pkg;
  localparam int MAX_NODES = 128;
  localparam int MAX_EDGES = 1024;
  localparam int NODE_AW   = 7;
  localparam int ROW_AW    = 8;
  localparam int EDGE_AW   = 10;

  localparam logic [31:0] Q_ONE = 32'h8000_0000;

  typedef enum logic [2:0] {
    CMD_ROW   = 3'd0,
    CMD_EDGE  = 3'd1,
    CMD_SCORE = 3'd2,
    CMD_RUN   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_ITER_COUNT = 2'd1;
  localparam logic [1:0] REG_DAMPING    = 2'd2;
endpackage

// File: rtl/core/pr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/core/pr_div.sv
// ----------------------------------------------------------------------------
// PageRank engine divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [10:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [10:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [11:0] trial;

  assign trial = {rem_r, quo_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 11'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[10:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// File: rtl/core/pagerank_push_csr_engine.sv
// ----------------------------------------------------------------------------
// PageRank push engine over a compressed-row graph
// Loads row pointers, edge targets and scores, runs push iterations, reads scores.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  in      | in_valid/in_ready, cmd index value  | host to engine
//  out     | out_valid/out_ready, data status    | engine to host
//  cfg     | cfg_valid/cfg_ready, index data     | host to engine
// Load commands answer in the next cycle, a score read after the S_READ state.
// During a run the shared divider and the single memory ports set the pace.
// Reset is synchronous; the memories are not cleared and need no sweep.
// The input is not ready while a command is at work or a word waits unread.
`timescale 1ns / 1ps
`include "pagerank_push_csr_engine_defines.svh"
module pagerank_push_csr_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [10:0] in_index,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_BASE, S_ITER, S_FILL, S_RLO, S_RHI, S_RCHK, S_SDIV,
    S_EADDR, S_TGT, S_ADD, S_EINC, S_NEXTU, S_CRD, S_CWR
  } state_t;

  state_t       state_r, state_nxt;
  logic [7:0]   node_count_r;
  logic [9:0]   iter_count_r;
  logic [31:0]  damping_r;

  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_data_r, out_data_nxt;
  logic         out_status_r, out_status_nxt;

  logic [7:0]   n_r, n_nxt;
  logic [31:0]  d_r, d_nxt;
  logic [31:0]  base_r, base_nxt;
  logic [9:0]   it_r, it_nxt;
  logic [6:0]   i_r, i_nxt;
  logic [6:0]   u_r, u_nxt;
  logic [10:0]  lo_r, lo_nxt;
  logic [10:0]  hi_r, hi_nxt;
  logic [10:0]  e_r, e_nxt;
  logic [6:0]   t_r, t_nxt;
  logic [32:0]  prod_r, prod_nxt;
  logic [31:0]  share_r, share_nxt;

  logic [7:0]   n_clamp;
  logic [31:0]  d_clamp;
  logic [63:0]  mul_full;
  logic [32:0]  add_sum;
  logic         accept;

  logic         div_start;
  logic [31:0]  div_dividend;
  logic [10:0]  div_divisor;
  logic         div_done;
  logic [31:0]  div_q;

  logic               row_we, edge_we, cur_we, nxt_we;
  logic [ROW_AW-1:0]  row_wa, row_ra;
  logic [10:0]        row_wd, row_rd;
  logic [EDGE_AW-1:0] edge_wa, edge_ra;
  logic [6:0]         edge_wd, edge_rd;
  logic [NODE_AW-1:0] cur_wa, cur_ra, nxt_wa, nxt_ra;
  logic [31:0]        cur_wd, cur_rd, nxt_wd, nxt_rd;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

  assign n_clamp  = (node_count_r > 8'(MAX_NODES)) ? 8'(MAX_NODES) : node_count_r;
  assign d_clamp  = (damping_r > Q_ONE) ? Q_ONE : damping_r;
  assign mul_full = d_r * cur_rd;
  assign add_sum  = {1'b0, nxt_rd} + {1'b0, share_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 8'd100;
      iter_count_r <= 10'd1000;
      damping_r    <= 32'd1825361101;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_data[7:0];
        REG_ITER_COUNT: iter_count_r <= cfg_data[9:0];
        REG_DAMPING:    damping_r    <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    n_nxt = n_r;  d_nxt = d_r;  base_nxt = base_r;  it_nxt = it_r;
    i_nxt = i_r;  u_nxt = u_r;  lo_nxt = lo_r;  hi_nxt = hi_r;
    e_nxt = e_r;  t_nxt = t_r;  prod_nxt = prod_r;  share_nxt = share_r;

    div_start    = 1'b0;
    div_dividend = 32'(Q_ONE - d_clamp);
    div_divisor  = {3'b000, n_clamp};

    row_we = 1'b0;  row_wa = in_index[ROW_AW-1:0];  row_wd = in_value[10:0];
    row_ra = {1'b0, u_r};
    edge_we = 1'b0;  edge_wa = in_index[EDGE_AW-1:0];  edge_wd = in_value[6:0];
    edge_ra = e_r[EDGE_AW-1:0];
    cur_we = 1'b0;  cur_wa = in_index[NODE_AW-1:0];  cur_wd = in_value;
    cur_ra = in_index[NODE_AW-1:0];
    nxt_we = 1'b0;  nxt_wa = i_r;  nxt_wd = base_r;  nxt_ra = i_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt   = '0;
          out_status_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          priority case (in_cmd)
            CMD_ROW: begin
              if (in_index > 11'(MAX_NODES) || in_value > 32'(MAX_EDGES)) begin
                out_status_nxt = 1'b1;
              end else begin
                row_we = 1'b1;
              end
            end
            CMD_EDGE: begin
              if (in_index >= 11'(MAX_EDGES) || in_value >= 32'(MAX_NODES)) begin
                out_status_nxt = 1'b1;
              end else begin
                edge_we = 1'b1;
              end
            end
            CMD_SCORE: begin
              if (in_index >= 11'(MAX_NODES)) begin
                out_status_nxt = 1'b1;
              end else begin
                cur_we = 1'b1;
              end
            end
            CMD_RUN: begin
              if (n_clamp != 8'd0) begin
                out_valid_nxt = 1'b0;
                n_nxt     = n_clamp;
                d_nxt     = d_clamp;
                div_start = 1'b1;
                state_nxt = S_BASE;
              end
            end
            CMD_READ: begin
              if (in_index >= 11'(MAX_NODES)) begin
                out_status_nxt = 1'b1;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            default: out_status_nxt = 1'b1;
          endcase
        end
      end
      S_READ: begin
        out_data_nxt   = cur_rd;
        out_status_nxt = 1'b0;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_BASE: begin
        if (div_done) begin
          base_nxt  = div_q;
          it_nxt    = '0;
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        if (it_r == iter_count_r) begin
          out_data_nxt   = '0;
          out_status_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          i_nxt     = '0;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        nxt_we = 1'b1;
        if ({1'b0, i_r} == n_r - 8'd1) begin
          u_nxt     = '0;
          state_nxt = S_RLO;
        end else begin
          i_nxt = i_r + 7'd1;
        end
      end
      S_RLO: begin
        cur_ra    = u_r;
        state_nxt = S_RHI;
      end
      S_RHI: begin
        row_ra    = {1'b0, u_r} + 8'd1;
        lo_nxt    = row_rd;
        prod_nxt  = mul_full[63:31];
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (row_rd <= lo_r) begin
          state_nxt = S_NEXTU;
        end else begin
          hi_nxt       = row_rd;
          e_nxt        = lo_r;
          div_start    = 1'b1;
          div_dividend = prod_r[32] ? 32'hFFFF_FFFF : prod_r[31:0];
          div_divisor  = row_rd - lo_r;
          state_nxt    = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_done) begin
          share_nxt = div_q;
          state_nxt = S_EADDR;
        end
      end
      S_EADDR: begin
        state_nxt = S_TGT;
      end
      S_TGT: begin
        nxt_ra = edge_rd;
        t_nxt  = edge_rd;
        if ({1'b0, edge_rd} < n_r) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_EINC;
        end
      end
      S_ADD: begin
        nxt_we    = 1'b1;
        nxt_wa    = t_r;
        nxt_wd    = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
        state_nxt = S_EINC;
      end
      S_EINC: begin
        e_nxt = e_r + 11'd1;
        if (e_r + 11'd1 == hi_r) begin
          state_nxt = S_NEXTU;
        end else begin
          state_nxt = S_EADDR;
        end
      end
      S_NEXTU: begin
        if ({1'b0, u_r} == n_r - 8'd1) begin
          i_nxt     = '0;
          state_nxt = S_CRD;
        end else begin
          u_nxt     = u_r + 7'd1;
          state_nxt = S_RLO;
        end
      end
      S_CRD: begin
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cur_we = 1'b1;
        cur_wa = i_r;
        cur_wd = nxt_rd;
        if ({1'b0, i_r} == n_r - 8'd1) begin
          it_nxt    = it_r + 10'd1;
          state_nxt = S_ITER;
        end else begin
          i_nxt     = i_r + 7'd1;
          state_nxt = S_CRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    base_r  <= base_nxt;
    it_r    <= it_nxt;
    i_r     <= i_nxt;
    u_r     <= u_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    e_r     <= e_nxt;
    t_r     <= t_nxt;
    prod_r  <= prod_nxt;
    share_r <= share_nxt;
  end

  pr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  pr_ram #(.WIDTH(11), .DEPTH(MAX_NODES + 1)) u_row_ram (
    .clk (clk), .wr_en (row_we), .wr_addr (row_wa), .wr_data (row_wd),
    .rd_addr (row_ra), .rd_data (row_rd)
  );

  pr_ram #(.WIDTH(7), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk (clk), .wr_en (edge_we), .wr_addr (edge_wa), .wr_data (edge_wd),
    .rd_addr (edge_ra), .rd_data (edge_rd)
  );

  pr_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_cur_ram (
    .clk (clk), .wr_en (cur_we), .wr_addr (cur_wa), .wr_data (cur_wd),
    .rd_addr (cur_ra), .rd_data (cur_rd)
  );

  pr_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_nxt_ram (
    .clk (clk), .wr_en (nxt_we), .wr_addr (nxt_wa), .wr_data (nxt_wd),
    .rd_addr (nxt_ra), .rd_data (nxt_rd)
  );

  `PR_ASSERT_NOW(a_busy_no_word, state_r != S_IDLE && state_r != S_READ, !out_valid_r)
  `PR_ASSERT_NOW(a_add_in_range, state_r == S_ADD, {1'b0, t_r} < n_r)
  `PR_ASSERT_NOW(a_edge_in_row, state_r == S_EADDR, e_r < hi_r && e_r >= lo_r)
  `PR_ASSERT_NEXT(a_run_blocks, accept && in_cmd == CMD_RUN && n_clamp != 8'd0, !in_ready)
endmodule
